>>> src/dtwl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtwl_pkg
// Shared types and constants for the DDS tuning word loader.
// ----------------------------------------------------------------------------
package dtwl_pkg;

    localparam int FREQ_W   = 32;
    localparam int RATIO_W  = 32;
    localparam int PROD_W   = FREQ_W + RATIO_W;
    localparam int TW_W     = 28;
    localparam int HALF_W   = 14;
    localparam int WORD_W   = 16;
    localparam int MODE_W   = 2;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = 3;
    localparam int ROUND_SH = 37;

    localparam logic [RATIO_W-1:0] RATIO_RESET = 32'hE510_9EC2;

    localparam logic [WORD_W-1:0] CTRL_RESET  = 16'h0100;
    localparam logic [WORD_W-1:0] CTRL_SET0   = 16'h2000;
    localparam logic [WORD_W-1:0] CTRL_SET1   = 16'h2C00;
    localparam logic [WORD_W-1:0] FREQ_TAG0   = 16'h4000;
    localparam logic [WORD_W-1:0] FREQ_TAG1   = 16'h8000;
    localparam logic [WORD_W-1:0] PHASE_TAG0  = 16'hC000;
    localparam logic [WORD_W-1:0] PHASE_TAG1  = 16'hE000;

    localparam logic [IDX_W-1:0] FREQ_LAST_IDX = 3'd2;
    localparam logic [IDX_W-1:0] INIT_LAST_IDX = 3'd6;

    // register index decode: paddr[2] selects the 32-bit register slot
    localparam logic REG_TUNING_RATIO = 1'b0;

    typedef enum logic [MODE_W-1:0] {
        MODE_FREQ_Q = 2'd0,
        MODE_FREQ_HZ = 2'd1,
        MODE_INIT = 2'd2,
        MODE_UNUSED = 2'd3
    } mode_t;

    typedef enum logic {
        CMD_FREQ = 1'b0,
        CMD_INIT = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic              set;
        logic [TW_W-1:0]   tw;
    } cmd_t;

endpackage
`default_nettype wire

>>> src/dtwl_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtwl_if
// Valid/ready channels: frequency requests in, DDS command words out.
// ----------------------------------------------------------------------------
interface dtwl_req_if;
    logic                       valid;
    logic                       ready;
    logic [dtwl_pkg::MODE_W-1:0] mode;
    logic [dtwl_pkg::FREQ_W-1:0] freq_value;

    modport source (output valid, output mode, output freq_value, input ready);
    modport sink   (input valid, input mode, input freq_value, output ready);
endinterface

interface dtwl_word_if;
    logic                       valid;
    logic                       ready;
    logic [dtwl_pkg::WORD_W-1:0] spi_word;
    logic                       last_word;

    modport source (output valid, output spi_word, output last_word, input ready);
    modport sink   (input valid, input spi_word, input last_word, output ready);
endinterface
`default_nettype wire

>>> src/dtwl_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtwl_front
// Accepts requests, tracks the active register set, multiplies the frequency
// by the tuning ratio and hands rounded commands to the queue.
// ----------------------------------------------------------------------------
module dtwl_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [dtwl_pkg::RATIO_W-1:0]  tuning_ratio,
    dtwl_req_if.sink                           req,
    output dtwl_pkg::cmd_t                     push_cmd,
    output logic                               push_valid,
    input  wire logic                          push_ready
);
    import dtwl_pkg::*;

    logic               st_valid_reg, st_valid_next;
    cmd_kind_t          st_kind_reg;
    logic               st_set_reg;
    logic [PROD_W-1:0]  st_prod_reg;
    logic               active_set_reg, active_set_next;

    logic               accept;
    logic               load;
    mode_t              mode;
    logic [FREQ_W-1:0]  operand;
    logic [PROD_W-1:0]  prod;
    logic [TW_W-1:0]    tw;

    assign mode      = mode_t'(req.mode);
    assign req.ready = !st_valid_reg || push_ready;
    assign accept    = req.valid && req.ready;
    assign load      = accept && (mode != MODE_UNUSED);

    always_comb
    begin
        if (mode == MODE_FREQ_HZ)
        begin
            operand = {req.freq_value[FREQ_W-8:0], 7'd0};
        end
        else
        begin
            operand = req.freq_value;
        end
    end

    assign prod = PROD_W'(operand) * PROD_W'(tuning_ratio);

    always_comb
    begin
        st_valid_next   = st_valid_reg;
        active_set_next = active_set_reg;
        if (load)
        begin
            st_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            st_valid_next = 1'b0;
        end
        if (load)
        begin
            if (mode == MODE_INIT)
            begin
                active_set_next = 1'b0;
            end
            else
            begin
                active_set_next = !active_set_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg   <= 1'b0;
            active_set_reg <= 1'b0;
        end
        else
        begin
            st_valid_reg   <= st_valid_next;
            active_set_reg <= active_set_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            st_kind_reg <= (mode == MODE_INIT) ? CMD_INIT : CMD_FREQ;
            st_set_reg  <= active_set_reg;
            st_prod_reg <= prod;
        end
    end

    // round half-up on bit 36, keep bits 63:37 zero-extended to 28 bits
    assign tw = TW_W'({1'b0, st_prod_reg[PROD_W-1:ROUND_SH]})
              + TW_W'(st_prod_reg[ROUND_SH-1]);

    assign push_valid    = st_valid_reg;
    assign push_cmd.kind = st_kind_reg;
    assign push_cmd.set  = st_set_reg;
    assign push_cmd.tw   = tw;

endmodule
`default_nettype wire

>>> src/dtwl_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtwl_queue
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
module dtwl_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire dtwl_pkg::cmd_t push_cmd,
    input  wire logic           push_valid,
    output logic                push_ready,
    output dtwl_pkg::cmd_t      pop_cmd,
    output logic                pop_valid,
    input  wire logic           pop_ready
);
    import dtwl_pkg::*;

    cmd_t        entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

>>> src/dtwl_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtwl_back
// Expands each queued command into its DDS command words, one per beat,
// through an output register.
// ----------------------------------------------------------------------------
module dtwl_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire dtwl_pkg::cmd_t pop_cmd,
    input  wire logic           pop_valid,
    output logic                pop_ready,
    dtwl_word_if.source         word
);
    import dtwl_pkg::*;

    logic               out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]  out_word_reg;
    logic               out_last_reg;
    logic [IDX_W-1:0]   idx_reg, idx_next;

    logic               load;
    logic               is_last;
    logic [WORD_W-1:0]  cur_word;
    logic [WORD_W-1:0]  freq_tag;
    logic [WORD_W-1:0]  ctrl;

    assign load = pop_valid && (!out_valid_reg || word.ready);

    assign freq_tag = pop_cmd.set ? FREQ_TAG1 : FREQ_TAG0;
    assign ctrl     = pop_cmd.set ? CTRL_SET1 : CTRL_SET0;

    always_comb
    begin
        cur_word = ctrl;
        is_last  = 1'b0;
        unique case (pop_cmd.kind)
            CMD_FREQ:
            begin
                is_last = (idx_reg == FREQ_LAST_IDX);
                unique case (idx_reg)
                    3'd0:    cur_word = freq_tag | WORD_W'(pop_cmd.tw[HALF_W-1:0]);
                    3'd1:    cur_word = freq_tag | WORD_W'(pop_cmd.tw[TW_W-1:HALF_W]);
                    default: cur_word = ctrl;
                endcase
            end
            CMD_INIT:
            begin
                is_last = (idx_reg == INIT_LAST_IDX);
                unique case (idx_reg)
                    3'd0:    cur_word = CTRL_SET0 | CTRL_RESET;
                    3'd1:    cur_word = FREQ_TAG0;
                    3'd2:    cur_word = FREQ_TAG0;
                    3'd3:    cur_word = PHASE_TAG0;
                    3'd4:    cur_word = FREQ_TAG1;
                    3'd5:    cur_word = FREQ_TAG1;
                    default: cur_word = PHASE_TAG1;
                endcase
            end
            default:
            begin
                cur_word = ctrl;
                is_last  = 1'b1;
            end
        endcase
    end

    assign pop_ready = load && is_last;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        idx_next       = idx_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            idx_next       = is_last ? '0 : idx_reg + 1'b1;
        end
        else if (word.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_word_reg <= cur_word;
            out_last_reg <= is_last;
        end
    end

    assign word.valid     = out_valid_reg;
    assign word.spi_word  = out_word_reg;
    assign word.last_word = out_last_reg;

endmodule
`default_nettype wire

>>> src/dds_tuning_word_loader.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dds_tuning_word_loader
// Turns frequency requests into 16-bit command words for a ping-pong DDS.
//
// Usage:
//   freq_in  : valid/ready request beats (mode, freq_value). Mode 0 is Q25.7,
//              mode 1 whole Hz, mode 2 the chip reset sequence, mode 3 is
//              accepted and dropped.
//   cmd_out  : valid/ready word beats (spi_word, last_word); last_word marks
//              the final word of a request.
//   APB      : tuning_ratio at address 0, written while the block is idle.
//   Path     : front stage register, queue entry, then output register.
//   Throughput: one word per cycle from the back-end output register while
//              cmd_out is ready; a frequency request gives 3 words, a reset one 7.
//              The front multiplies while the back emits, with a two-entry
//              command queue between them.
//   Reset    : queue and output empty, register set 0, ratio 0xE5109EC2.
//   Stall    : a held cmd_out freezes its word; the queue and front stage
//              fill, then freq_in.ready drops.
// ----------------------------------------------------------------------------
module dds_tuning_word_loader (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [dtwl_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [dtwl_pkg::DATA_W-1:0]   pwdata,
    output logic      [dtwl_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    dtwl_req_if.sink                           freq_in,
    dtwl_word_if.source                        cmd_out
);
    import dtwl_pkg::*;

    logic [RATIO_W-1:0] tuning_ratio_reg;
    logic               cfg_write;

    cmd_t               push_cmd;
    logic               push_valid;
    logic               push_ready;
    cmd_t               pop_cmd;
    logic               pop_valid;
    logic               pop_ready;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                     && (paddr[2] == REG_TUNING_RATIO);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tuning_ratio_reg <= RATIO_RESET;
        end
        else if (cfg_write)
        begin
            tuning_ratio_reg <= pwdata;
        end
    end

    assign prdata = (paddr[2] == REG_TUNING_RATIO) ? tuning_ratio_reg : '0;

    dtwl_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .tuning_ratio (tuning_ratio_reg),
        .req          (freq_in),
        .push_cmd     (push_cmd),
        .push_valid   (push_valid),
        .push_ready   (push_ready)
    );

    dtwl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cmd   (push_cmd),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_cmd    (pop_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    dtwl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_cmd   (pop_cmd),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .word      (cmd_out)
    );

endmodule
`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the DDS tuning word loader. Frequency and reset
// requests go in over the request channel, and every command word that comes
// out is compared with a local model of the tuning-word arithmetic and of
// the ping-pong register set, or with the fixed words of a directed row.
// A short table of directed requests comes first. Random traffic follows
// under several tuning ratios, written over APB and read back while the
// block is idle. Both channels stall at random except in one calm phase.
// ----------------------------------------------------------------------------
module tb_top;
    import dtwl_pkg::*;

    localparam logic [ADDR_W-1:0] TUNING_RATIO_ADDR = 3'd0;
    localparam int IDLE_PCT    = 22;
    localparam int DRAIN_CYC   = 8;
    localparam int PHASE_ITEMS = 38;

    localparam logic [0:6][WORD_W-1:0] INIT_SEQ = {
        CTRL_SET0 | CTRL_RESET, FREQ_TAG0, FREQ_TAG0, PHASE_TAG0,
        FREQ_TAG1, FREQ_TAG1, PHASE_TAG1
    };
    localparam logic [0:6][WORD_W-1:0] NO_WORDS = '0;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
    } cmd_beat_t;

    typedef struct packed {
        mode_t                    mode;
        logic [FREQ_W-1:0]        freq;
        logic [2:0]               n_fixed;
        logic [0:6][WORD_W-1:0]   fixed_words;
    } req_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;

    dtwl_req_if  req_bus ();
    dtwl_word_if word_bus ();

    dds_tuning_word_loader DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .freq_in (req_bus),
        .cmd_out (word_bus)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // model state
    logic [RATIO_W-1:0] ratio_model;
    logic               set_model;
    cmd_beat_t          pending_words[$];
    int unsigned        mism_count;
    bit                 calm;

    req_row_t directed_rows [19] = '{
        '{MODE_INIT,    32'h0000_0000, 3'd7, INIT_SEQ},
        '{MODE_FREQ_Q,  32'h0000_0000, 3'd3,
          {FREQ_TAG0, FREQ_TAG0, CTRL_SET0, 16'h0, 16'h0, 16'h0, 16'h0}},
        '{MODE_FREQ_HZ, 32'h0000_0000, 3'd3,
          {FREQ_TAG1, FREQ_TAG1, CTRL_SET1, 16'h0, 16'h0, 16'h0, 16'h0}},
        '{MODE_FREQ_Q,  32'hFFFF_FFFF, 3'd0, NO_WORDS},
        '{MODE_FREQ_Q,  32'h0000_0001, 3'd0, NO_WORDS},
        '{MODE_FREQ_HZ, 32'hFFFF_FFFF, 3'd0, NO_WORDS},
        '{MODE_FREQ_HZ, 32'h01FF_FFFF, 3'd0, NO_WORDS},
        // shifts out to zero
        '{MODE_FREQ_HZ, 32'h0200_0000, 3'd3,
          {FREQ_TAG0, FREQ_TAG0, CTRL_SET0, 16'h0, 16'h0, 16'h0, 16'h0}},
        '{MODE_UNUSED,  32'h1234_5678, 3'd0, NO_WORDS},
        '{MODE_FREQ_Q,  32'h0000_0080, 3'd0, NO_WORDS},
        '{MODE_FREQ_HZ, 32'd1000,      3'd0, NO_WORDS},
        '{MODE_INIT,    32'hFFFF_FFFF, 3'd7, INIT_SEQ},
        '{MODE_FREQ_Q,  32'h8000_0000, 3'd0, NO_WORDS},
        // init with set 1 active
        '{MODE_INIT,    32'h5A5A_5A5A, 3'd7, INIT_SEQ},
        '{MODE_FREQ_Q,  32'h7FFF_FFFF, 3'd0, NO_WORDS},
        '{MODE_FREQ_HZ, 32'h00FF_FFFF, 3'd0, NO_WORDS},
        '{MODE_UNUSED,  32'hFFFF_FFFF, 3'd0, NO_WORDS},
        '{MODE_FREQ_Q,  32'h5555_5555, 3'd0, NO_WORDS},
        '{MODE_FREQ_HZ, 32'hAAAA_AAAA, 3'd0, NO_WORDS}
    };

    function automatic logic [TW_W-1:0] calc_ftw(input logic [FREQ_W-1:0] q,
                                                 input logic [RATIO_W-1:0] ratio);
        logic [PROD_W-1:0] prod;
        logic [PROD_W-1:0] half;
        logic [31:0]       tw;
        prod = {{RATIO_W{1'b0}}, q} * {{FREQ_W{1'b0}}, ratio};
        half = prod >> 36;
        tw = half[32:1];
        if (half[0])
            tw = tw + 32'd1;
        return tw[TW_W-1:0];
    endfunction

    function automatic void predict_words(input mode_t m, input logic [FREQ_W-1:0] f,
                                          ref cmd_beat_t words[$]);
        logic [FREQ_W-1:0] q;
        logic [TW_W-1:0]   tw;
        logic [WORD_W-1:0] tag;
        words.delete();
        case (m)
            MODE_INIT:
            begin
                for (int i = 0; i < 7; i++)
                    words.push_back('{INIT_SEQ[i], i == 6});
                set_model = 1'b0;
            end
            MODE_FREQ_Q, MODE_FREQ_HZ:
            begin
                q = (m == MODE_FREQ_HZ) ? (f << 7) : f;
                tw = calc_ftw(q, ratio_model);
                tag = set_model ? FREQ_TAG1 : FREQ_TAG0;
                words.push_back('{tag | {2'b00, tw[HALF_W-1:0]}, 1'b0});
                words.push_back('{tag | {2'b00, tw[TW_W-1:HALF_W]}, 1'b0});
                words.push_back('{set_model ? CTRL_SET1 : CTRL_SET0, 1'b1});
                set_model = ~set_model;
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void note_mismatch(input string msg);
        mism_count++;
        if (mism_count <= 10)
            $display("MISMATCH @%0t: %s", $realtime, msg);
    endfunction

    function automatic logic [FREQ_W-1:0] pick_freq();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 50)
            return $urandom;
        else if (r < 65)
            return $urandom_range(4095);
        else if (r < 75)
            return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
        else
            return $urandom >> $urandom_range(31);
    endfunction

    task automatic send_request(input mode_t m, input logic [FREQ_W-1:0] f,
                                input logic [2:0] n_fixed,
                                input logic [0:6][WORD_W-1:0] fixed_words);
        cmd_beat_t calc[$];
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            req_bus.valid <= 1'b0;
            @(posedge clk);
        end
        req_bus.valid      <= 1'b1;
        req_bus.mode       <= m;
        req_bus.freq_value <= f;
        do @(posedge clk); while (!req_bus.ready);
        predict_words(m, f, calc);
        if (n_fixed != 0)
        begin
            for (int i = 0; i < n_fixed; i++)
                pending_words.push_back('{fixed_words[i], i == n_fixed - 1});
        end
        else
        begin
            foreach (calc[i])
                pending_words.push_back(calc[i]);
        end
    endtask

    task automatic drain();
        req_bus.valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [DATA_W-1:0] wdata,
                              output logic [DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= TUNING_RATIO_ADDR;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic load_ratio(input logic [RATIO_W-1:0] ratio);
        logic [DATA_W-1:0] rd;
        apb_access(1'b1, ratio, rd);
        ratio_model = ratio;
        apb_access(1'b0, '0, rd);
        if (rd !== ratio)
            note_mismatch($sformatf("tuning_ratio readback exp %08h got %08h", ratio, rd));
    endtask

    task automatic random_phase(input int unsigned n_items);
        int unsigned sent;
        int unsigned r;
        mode_t m;
        sent = 0;
        while (sent < n_items)
        begin
            r = $urandom_range(99);
            if (r < 44)
                m = MODE_FREQ_Q;
            else if (r < 84)
                m = MODE_FREQ_HZ;
            else if (r < 94)
                m = MODE_INIT;
            else
                m = MODE_UNUSED;
            send_request(m, pick_freq(), 3'd0, NO_WORDS);
            if (m != MODE_UNUSED)
                sent++;
        end
    endtask

    // output side: random backpressure and checking
    always @(posedge clk)
        word_bus.ready <= calm || ($urandom_range(99) >= IDLE_PCT);

    always @(posedge clk)
    begin
        cmd_beat_t want;
        if (rst_n && word_bus.valid && word_bus.ready)
        begin
            if (pending_words.size() == 0)
                note_mismatch($sformatf("unexpected beat %04h last=%0b",
                                        word_bus.spi_word, word_bus.last_word));
            else
            begin
                want = pending_words.pop_front();
                if (word_bus.spi_word !== want.word)
                    note_mismatch($sformatf("spi_word exp %04h got %04h",
                                            want.word, word_bus.spi_word));
                if (word_bus.last_word !== want.last)
                    note_mismatch($sformatf("last_word exp %0b got %0b",
                                            want.last, word_bus.last_word));
            end
        end
    end

    initial
    begin
        logic [RATIO_W-1:0] ratios [6];
        ratios = '{32'h0, 32'hFFFF_FFFF, 32'h4000_0000, 32'h1, 32'h0, RATIO_RESET};
        ratios[4] = $urandom;
        mism_count = 0;
        calm = 1'b0;
        ratio_model = RATIO_RESET;
        set_model = 1'b0;
        rst_n   <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        req_bus.valid      <= 1'b0;
        req_bus.mode       <= MODE_FREQ_Q;
        req_bus.freq_value <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].mode, directed_rows[i].freq,
                         directed_rows[i].n_fixed, directed_rows[i].fixed_words);
        random_phase(PHASE_ITEMS / 3);

        for (int p = 0; p < 6; p++)
        begin
            drain();
            load_ratio(ratios[p]);
            calm = (p == 2);
            random_phase(PHASE_ITEMS);
        end
        calm = 1'b0;

        drain();
        if (mism_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
